/* rtl/core/t2u_pkg.sv */
// Shared types and constants of the text to UTF-8 transcoder.
package t2u_pkg;

   // Input encodings selected by the encoding register.
   typedef enum logic [1:0] {
      ENC_LATIN1   = 2'd0,
      ENC_UTF16_BOM = 2'd1,
      ENC_UTF16_BE = 2'd2,
      ENC_PASSTHRU = 2'd3
   } enc_type;

   // Register index of the encoding register (byte address 4 * index).
   localparam logic CSR_IDX_ENCODING = 1'b0;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // UTF-8 lead and continuation patterns.
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // Byte order mark for big endian.
   localparam logic [7:0] BOM_BE_FIRST  = 8'hFE;
   localparam logic [7:0] BOM_BE_SECOND = 8'hFF;

   // Top six bits of a high and a low surrogate.
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

   // The output bytes caused by one input transfer.
   typedef struct packed {
      logic [3:0][7:0] bytes;     // emitted in order from bytes[0]
      logic [1:0]      count_m1;  // number of bytes minus one
      logic            valid;     // zero for the empty end marker
      logic            last;      // the input transfer closed the string
   } bundle_type;

endpackage

/* rtl/core/t2u_front.sv */
// Front end: decodes each input byte into a bundle of UTF-8 bytes.
module t2u_front (
   input  logic                clock,
   input  logic                reset,
   input  t2u_pkg::enc_type    encoding,
   input  logic                in_fire,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output t2u_pkg::bundle_type bundle,
   output logic                bundle_push
);
   import t2u_pkg::*;

   logic        phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [1:0]  marks_ff, marks_in;
   logic        be_ff, be_in;
   logic [9:0]  hbits_ff, hbits_in;
   logic        pending_ff, pending_in;
   logic        ended_ff, ended_in;

   logic [2:0]      n;
   logic [3:0][7:0] bytes;
   logic [15:0]     unit;
   logic            unit_be;
   logic            is_hi, is_lo;
   logic [20:0]     cp;
   logic            with_mark;

   assign with_mark = (encoding == ENC_UTF16_BOM);
   assign unit_be   = with_mark ? be_ff : 1'b1;
   assign unit      = unit_be ? {held_ff, in_byte} : {in_byte, held_ff};
   assign is_hi     = (unit[15:10] == SURR_HIGH_TAG);
   assign is_lo     = (unit[15:10] == SURR_LOW_TAG);
   assign cp        = SUPPLEMENTARY_BASE + {1'b0, hbits_ff, unit[9:0]};

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      marks_in   = marks_ff;
      be_in      = be_ff;
      hbits_in   = hbits_ff;
      pending_in = pending_ff;
      ended_in   = ended_ff;
      n          = 3'd0;
      bytes      = '0;

      unique case (encoding)
         ENC_LATIN1: begin
            if (!ended_ff) begin
               if (in_byte == 8'd0) begin
                  ended_in = 1'b1;
               end else if (!in_byte[7]) begin
                  bytes[0] = in_byte;
                  n        = 3'd1;
               end else begin
                  bytes[0] = UTF8_LEAD2 | 8'(in_byte[7:6]);
                  bytes[1] = UTF8_CONT | 8'(in_byte[5:0]);
                  n        = 3'd2;
               end
            end
         end
         ENC_PASSTHRU: begin
            if (!ended_ff) begin
               if (in_byte == 8'd0) begin
                  ended_in = 1'b1;
               end else begin
                  bytes[0] = in_byte;
                  n        = 3'd1;
               end
            end
         end
         ENC_UTF16_BOM, ENC_UTF16_BE: begin
            if (with_mark && marks_ff < 2'd2) begin
               if (marks_ff == 2'd0) begin
                  held_in  = in_byte;
                  marks_in = 2'd1;
               end else begin
                  be_in    = (held_ff == BOM_BE_FIRST) && (in_byte == BOM_BE_SECOND);
                  marks_in = 2'd2;
               end
            end else if (!phase_ff) begin
               held_in  = in_byte;
               phase_in = 1'b1;
            end else begin
               phase_in   = 1'b0;
               pending_in = 1'b0;
               if (pending_ff && is_lo) begin
                  bytes[0] = UTF8_LEAD4 | 8'(cp[20:18]);
                  bytes[1] = UTF8_CONT | 8'(cp[17:12]);
                  bytes[2] = UTF8_CONT | 8'(cp[11:6]);
                  bytes[3] = UTF8_CONT | 8'(cp[5:0]);
                  n        = 3'd4;
               end else if (is_hi) begin
                  hbits_in   = unit[9:0];
                  pending_in = 1'b1;
               end else if (is_lo) begin
                  // A lone low surrogate is dropped.
                  n = 3'd0;
               end else if (unit < 16'h0080) begin
                  bytes[0] = unit[7:0];
                  n        = 3'd1;
               end else if (unit < 16'h0800) begin
                  bytes[0] = UTF8_LEAD2 | 8'(unit[10:6]);
                  bytes[1] = UTF8_CONT | 8'(unit[5:0]);
                  n        = 3'd2;
               end else begin
                  bytes[0] = UTF8_LEAD3 | 8'(unit[15:12]);
                  bytes[1] = UTF8_CONT | 8'(unit[11:6]);
                  bytes[2] = UTF8_CONT | 8'(unit[5:0]);
                  n        = 3'd3;
               end
            end
         end
         default: begin
            n = 3'd0;
         end
      endcase

      // The closing byte of a string returns every state bit to its reset value.
      if (in_last) begin
         phase_in   = 1'b0;
         held_in    = '0;
         marks_in   = '0;
         be_in      = 1'b0;
         hbits_in   = '0;
         pending_in = 1'b0;
         ended_in   = 1'b0;
      end
   end

   always_comb begin
      bundle.bytes    = bytes;
      bundle.count_m1 = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
      bundle.valid    = (n != 3'd0);
      bundle.last     = in_last;
      bundle_push     = in_fire && ((n != 3'd0) || in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         held_ff    <= '0;
         marks_ff   <= '0;
         be_ff      <= 1'b0;
         hbits_ff   <= '0;
         pending_ff <= 1'b0;
         ended_ff   <= 1'b0;
      end else if (in_fire) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         marks_ff   <= marks_in;
         be_ff      <= be_in;
         hbits_ff   <= hbits_in;
         pending_ff <= pending_in;
         ended_ff   <= ended_in;
      end
   end

endmodule

/* rtl/core/t2u_queue.sv */
// Small bundle queue between the decoding front end and the byte serialiser.
module t2u_queue #(
   parameter int unsigned DEPTH = t2u_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  t2u_pkg::bundle_type push_data,
   input  logic                pop,
   output t2u_pkg::bundle_type head,
   output logic                head_valid,
   output logic                full
);
   import t2u_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

   bundle_type       slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/t2u_back.sv */
// Back end: serialises each queued bundle into output byte transfers.
module t2u_back (
   input  logic                clock,
   input  logic                reset,
   input  t2u_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_byte_valid,
   output logic                out_last_of_run,
   output logic                out_string_end
);
   import t2u_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       run_ff, run_in;
   logic       send_ff, send_in;
   logic       step, final_byte;

   assign step       = head_valid && (!valid_ff || out_ready);
   assign final_byte = (idx_ff == head.count_m1);
   assign pop        = step && final_byte;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      run_in    = run_ff;
      send_in   = send_ff;
      if (step) begin
         valid_in  = 1'b1;
         byte_in   = head.bytes[idx_ff];
         bvalid_in = head.valid;
         run_in    = final_byte;
         send_in   = final_byte && head.last;
         idx_in    = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      run_ff    <= run_in;
      send_ff   <= send_in;
   end

   assign out_valid       = valid_ff;
   assign out_byte        = byte_ff;
   assign out_byte_valid  = bvalid_ff;
   assign out_last_of_run = run_ff;
   assign out_string_end  = send_ff;

endmodule

/* rtl/core/text_to_utf8_transcoder.sv */
// Top level of the text to UTF-8 transcoder with its register port.
//
// Bytes of an encoded text string enter one per transfer on the req_ channel
// (req_tlast on the final byte) and leave as UTF-8 bytes on the rsp_ channel,
// one byte per transfer and per cycle while rsp_tready is high. The front end
// decodes one input byte per cycle, unless the queue is full, into a bundle
// of zero to four output bytes and writes it to a queue of QUEUE_DEPTH
// entries; the back end reads that queue and sends one byte per cycle, while
// rsp_tready is high, through a registered output stage. An input byte yields
// k output bytes (at most three, for a UTF-16 code unit from 0x0800 up, or
// four for a surrogate pair); one that yields none and does not close a string
// adds nothing to the output, so the sustained rate is set by the output byte
// count, but never more than one input byte per cycle. The encoding register
// (address 0) selects Latin-1, UTF-16 led by a byte order mark, UTF-16 big
// endian or passthrough; the user must see that it is written only while the
// block is idle, which the block itself does not enforce.
module text_to_utf8_transcoder #(
   parameter int unsigned QUEUE_DEPTH = t2u_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_in_string
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] string_end
   output logic        rsp_tlast,   // last_of_run
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import t2u_pkg::*;

   enc_type    encoding_ff, encoding_in;
   logic       csr_write;
   logic       in_fire;
   bundle_type push_bundle, head_bundle;
   logic       push, pop, head_valid, queue_full;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_ENCODING);

   always_comb begin
      encoding_in = encoding_ff;
      if (csr_write) begin
         encoding_in = enc_type'(csr_pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= ENC_LATIN1;
      end else begin
         encoding_ff <= encoding_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ENCODING) ? {30'd0, encoding_ff} : 32'd0;

   assign req_tready = !queue_full;
   assign in_fire    = req_tvalid && req_tready;

   t2u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .encoding    (encoding_ff),
      .in_fire     (in_fire),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .bundle      (push_bundle),
      .bundle_push (push)
   );

   t2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_bundle),
      .pop        (pop),
      .head       (head_bundle),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   t2u_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head_bundle),
      .head_valid      (head_valid),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_byte        (rsp_tdata),
      .out_byte_valid  (rsp_tuser[0]),
      .out_last_of_run (rsp_tlast),
      .out_string_end  (rsp_tuser[1])
   );

   // An empty end marker only ever closes a string.
   a_marker_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1])
      else $error("empty end marker without closing flags");

   // The end of a string is always the end of a run.
   a_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("string end without last of run");

   // Nothing is in the output stage in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result transfer offered straight after reset");

   // The queue pops only when it has a bundle to give.
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the text to UTF-8 transcoder, with its own predictor.
module tb_top;
   import t2u_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned PHASES = 12;
   localparam int unsigned PHASE_ITEMS = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_end;
      logic       str_end;
   } utf8_result_t;

   typedef struct packed {
      enc_type    enc;
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [7:0] exp_data;
      logic       exp_valid;
      logic       exp_run_end;
      logic       exp_str_end;
   } text_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // last_in_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] out_byte
   logic [1:0]  rsp_tuser;           // [0] byte_valid, [1] string_end
   logic        rsp_tlast;           // last_of_run
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_to_utf8_transcoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   int unsigned  cycle_count = 0;
   int unsigned  error_count = 0;
   bit           calm = 1'b0;
   utf8_result_t awaited_utf8[$];
   utf8_result_t seen;
   utf8_result_t want;
   logic [7:0]   text_bytes[$];
   text_row_t    text_rows[28];

   // Predictor state.
   enc_type      pr_enc = ENC_LATIN1;
   logic         pr_phase = 1'b0;
   logic [7:0]   pr_held = 8'h00;
   logic [1:0]   pr_mark = 2'd0;
   logic         pr_be = 1'b0;
   logic [9:0]   pr_high = 10'd0;
   logic         pr_pending = 1'b0;
   logic         pr_ended = 1'b0;
   logic [7:0]   utf8_bytes[4];
   int           utf8_count;

   function automatic void append_awaited(utf8_result_t r);
      awaited_utf8 = {awaited_utf8, r};
   endfunction

   function automatic void append_text_byte(logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   function automatic void clear_text_state();
      pr_phase = 1'b0;
      pr_held = 8'h00;
      pr_mark = 2'd0;
      pr_be = 1'b0;
      pr_high = 10'd0;
      pr_pending = 1'b0;
      pr_ended = 1'b0;
   endfunction

   function automatic void put_utf8(logic [7:0] b);
      if (utf8_count < 4) begin
         utf8_bytes[utf8_count] = b;
         utf8_count++;
      end
   endfunction

   function automatic void encode_code_unit(logic [15:0] u);
      logic [20:0] cp;
      if (pr_pending) begin
         pr_pending = 1'b0;
         if (u[15:10] == SURR_LOW_TAG) begin
            cp = SUPPLEMENTARY_BASE + {1'b0, pr_high, u[9:0]};
            put_utf8(UTF8_LEAD4 | {5'd0, cp[20:18]});
            put_utf8(UTF8_CONT | {2'd0, cp[17:12]});
            put_utf8(UTF8_CONT | {2'd0, cp[11:6]});
            put_utf8(UTF8_CONT | {2'd0, cp[5:0]});
            return;
         end
      end
      if (u[15:10] == SURR_HIGH_TAG) begin
         pr_high = u[9:0];
         pr_pending = 1'b1;
         return;
      end
      if (u[15:10] == SURR_LOW_TAG)
         return;
      if (u < 16'h0080) begin
         put_utf8(u[7:0]);
      end else if (u < 16'h0800) begin
         put_utf8(UTF8_LEAD2 | {3'd0, u[10:6]});
         put_utf8(UTF8_CONT | {2'd0, u[5:0]});
      end else begin
         put_utf8(UTF8_LEAD3 | {4'd0, u[15:12]});
         put_utf8(UTF8_CONT | {2'd0, u[11:6]});
         put_utf8(UTF8_CONT | {2'd0, u[5:0]});
      end
   endfunction

   function automatic void decode_utf16_byte(logic [7:0] b, bit with_mark);
      logic        be;
      logic [15:0] u;
      if (with_mark && pr_mark < 2'd2) begin
         if (pr_mark == 2'd0) begin
            pr_held = b;
            pr_mark = 2'd1;
         end else begin
            pr_be = (pr_held == BOM_BE_FIRST) && (b == BOM_BE_SECOND);
            pr_mark = 2'd2;
         end
         return;
      end
      if (!pr_phase) begin
         pr_held = b;
         pr_phase = 1'b1;
         return;
      end
      pr_phase = 1'b0;
      be = with_mark ? pr_be : 1'b1;
      u = be ? {pr_held, b} : {b, pr_held};
      encode_code_unit(u);
   endfunction

   // Works out the output bytes of one accepted input transfer and, if asked,
   // queues them as awaited results.
   function automatic void predict_utf8(logic [7:0] b, logic last, bit record);
      utf8_result_t r;
      utf8_count = 0;
      case (pr_enc)
         ENC_LATIN1: begin
            if (!pr_ended) begin
               if (b == 8'h00) begin
                  pr_ended = 1'b1;
               end else if (b < 8'h80) begin
                  put_utf8(b);
               end else begin
                  put_utf8(UTF8_LEAD2 | {6'd0, b[7:6]});
                  put_utf8(UTF8_CONT | {2'd0, b[5:0]});
               end
            end
         end
         ENC_UTF16_BOM: decode_utf16_byte(b, 1'b1);
         ENC_UTF16_BE:  decode_utf16_byte(b, 1'b0);
         default: begin
            if (!pr_ended) begin
               if (b == 8'h00)
                  pr_ended = 1'b1;
               else
                  put_utf8(b);
            end
         end
      endcase
      if (record) begin
         if (utf8_count == 0 && last) begin
            r = '{8'h00, 1'b0, 1'b1, 1'b1};
            append_awaited(r);
         end
         for (int k = 0; k < utf8_count; k++) begin
            r.data = utf8_bytes[k];
            r.valid = 1'b1;
            r.run_end = (k == utf8_count - 1);
            r.str_end = (k == utf8_count - 1) && last;
            append_awaited(r);
         end
      end
      if (last)
         clear_text_state();
   endfunction

   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 10);
   endfunction

   // Sends one byte, waits for its transfer and, if asked, records what it should cause.
   task automatic send_byte(input logic [7:0] b, input logic last, input bit record);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_utf8(b, last, record);
   endtask

   task automatic write_encoding(input enc_type enc);
      logic [31:0] wd;
      wd = $urandom();
      wd[1:0] = enc;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {CSR_IDX_ENCODING, 2'b00};
      csr_pwdata <= wd;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // Read the register back in the following access.
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[1:0] !== enc) begin
         error_count++;
         $display("%0t: encoding read back: expected %0d, got %0d", $time, enc,
                  csr_prdata[1:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      pr_enc = enc;
   endtask

   // The register may only change once the block has gone quiet.
   task automatic change_encoding(input enc_type enc);
      req_tvalid <= 1'b0;
      while (awaited_utf8.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      write_encoding(enc);
   endtask

   function automatic void push_unit(logic [15:0] u, logic be);
      if (be) begin
         append_text_byte(u[15:8]);
         append_text_byte(u[7:0]);
      end else begin
         append_text_byte(u[7:0]);
         append_text_byte(u[15:8]);
      end
   endfunction

   // Builds one string for the given encoding; mostly well formed, some noise.
   function automatic void build_string(enc_type enc);
      int unsigned n;
      int unsigned kind;
      logic [15:0] u;
      logic [7:0]  m0;
      logic [7:0]  m1;
      logic        be;
      text_bytes.delete();
      if ($urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 6);
         repeat (n) append_text_byte(8'($urandom_range(0, 255)));
         return;
      end
      if (enc == ENC_LATIN1 || enc == ENC_PASSTHRU) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 19) == 0)
               append_text_byte(8'h00);
            else
               append_text_byte(8'($urandom_range(1, 255)));
         end
         return;
      end
      be = 1'b1;
      if (enc == ENC_UTF16_BOM) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            m0 = BOM_BE_FIRST;
            m1 = BOM_BE_SECOND;
         end else if (kind < 8) begin
            m0 = BOM_BE_SECOND;
            m1 = BOM_BE_FIRST;
         end else begin
            m0 = 8'($urandom_range(0, 255));
            m1 = 8'($urandom_range(0, 255));
         end
         be = (m0 == BOM_BE_FIRST) && (m1 == BOM_BE_SECOND);
         append_text_byte(m0);
         append_text_byte(m1);
      end
      n = $urandom_range(0, 4);
      repeat (n) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            push_unit(16'($urandom_range(16'h0000, 16'h007F)), be);
         end else if (kind < 45) begin
            push_unit(16'($urandom_range(16'h0080, 16'h07FF)), be);
         end else if (kind < 60) begin
            do u = 16'($urandom_range(16'h0800, 16'hFFFF)); while (u[15:11] == 5'b11011);
            push_unit(u, be);
         end else if (kind < 85) begin
            push_unit({SURR_HIGH_TAG, 10'($urandom())}, be);
            push_unit({SURR_LOW_TAG, 10'($urandom())}, be);
         end else if (kind < 93) begin
            push_unit({SURR_HIGH_TAG, 10'($urandom())}, be);
         end else begin
            push_unit({SURR_LOW_TAG, 10'($urandom())}, be);
         end
      end
      if (text_bytes.size() == 0 || $urandom_range(0, 9) == 0)
         append_text_byte(8'($urandom_range(0, 255)));
   endfunction

   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 10);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         if (awaited_utf8.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing awaited: expected none, got %h/%b/%b/%b",
                     $time, seen.data, seen.valid, seen.run_end, seen.str_end);
         end else begin
            want = awaited_utf8.pop_front();
            if (seen.data !== want.data) begin
               error_count++;
               $display("%0t: out_byte: expected %h, got %h", $time, want.data, seen.data);
            end
            if (seen.valid !== want.valid) begin
               error_count++;
               $display("%0t: byte_valid: expected %b, got %b", $time, want.valid,
                        seen.valid);
            end
            if (seen.run_end !== want.run_end) begin
               error_count++;
               $display("%0t: last_of_run: expected %b, got %b", $time, want.run_end,
                        seen.run_end);
            end
            if (seen.str_end !== want.str_end) begin
               error_count++;
               $display("%0t: string_end: expected %b, got %b", $time, want.str_end,
                        seen.str_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      text_row_t   row;
      enc_type     enc;
      int unsigned sent;
      utf8_result_t typed_result;
      text_rows = '{
         // Latin-1: plain, high bytes, then a NUL silences the rest.
         '{ENC_LATIN1,    8'h41, 1'b0, 1'b1, 8'h41, 1'b1, 1'b1, 1'b0},
         '{ENC_LATIN1,    8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_LATIN1,    8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_LATIN1,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_LATIN1,    8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
         // Passthrough, with a NUL and an empty end.
         '{ENC_PASSTHRU,  8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0},
         '{ENC_PASSTHRU,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_PASSTHRU,  8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
         // Big endian mark followed by a surrogate pair.
         '{ENC_UTF16_BOM, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'hD8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'h3D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'hDE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         // A one-byte string is only half a mark.
         '{ENC_UTF16_BOM, 8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
         // Little endian: a high half left pending and an odd trailing byte.
         '{ENC_UTF16_BOM, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'hD8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BOM, 8'h41, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
         // Big endian: the top code unit, an unpaired high half, a lone low half.
         '{ENC_UTF16_BE,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'hDB, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'h41, 1'b0, 1'b1, 8'h41, 1'b1, 1'b1, 1'b0},
         '{ENC_UTF16_BE,  8'hDF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
         '{ENC_UTF16_BE,  8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (text_rows[i]) begin
         row = text_rows[i];
         if (row.enc != pr_enc)
            change_encoding(row.enc);
         send_byte(row.data, row.last, !row.typed);
         if (row.typed) begin
            typed_result = '{row.exp_data, row.exp_valid, row.exp_run_end, row.exp_str_end};
            append_awaited(typed_result);
         end
      end

      // Each phase may stop part-way through a string, so the next encoding
      // picks up the state that the previous one left behind.
      for (int phase = 0; phase < PHASES; phase++) begin
         enc = (phase < 8) ? enc_type'(phase % 4) : enc_type'($urandom_range(0, 3));
         change_encoding(enc);
         calm = (phase == 6);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_string(enc);
            for (int i = 0; i < text_bytes.size() && sent < PHASE_ITEMS; i++) begin
               send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b1);
               sent++;
            end
         end
         calm = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (awaited_utf8.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
